// ===== src/cordic_sin_cos_q14_unit_defines.svh =====
// Assertion macros shared by the CORDIC sin/cos RTL.
// Bodies expect clk and rst_n to be visible at the point of use.
`ifndef CORDIC_SIN_COS_Q14_UNIT_DEFINES_SVH
`define CORDIC_SIN_COS_Q14_UNIT_DEFINES_SVH

// same-cycle implication
`define CSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// implication after a fixed number of cycles
`define CSC_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##dly (cons)) else $error(msg);

`endif

// ===== src/csc_pkg.sv =====
// Shared types, constants and the arctangent table for the CORDIC sin/cos unit.
// No dependencies.
`default_nettype none

package csc_pkg;

  localparam int MAX_ITERATIONS = 16;
  localparam int NUM_STAGES     = MAX_ITERATIONS + 1;
  localparam int STEP_W         = $clog2(NUM_STAGES);
  localparam int LATENCY        = NUM_STAGES;

  localparam int DATA_W  = 16;   // angle / cosine / sine ports
  localparam int VEC_W   = 18;   // internal x, y, z
  localparam int CNT_W   = 5;    // iteration_count register
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;

  localparam int ATAN_LEN   = 16;
  localparam int ATAN_IDX_W = 4;

  localparam logic [CNT_W-1:0] ITER_RESET = 5'd16;

  typedef logic signed [VEC_W-1:0] vec_word_t;

  localparam vec_word_t X_START = 18'sh026DD;  // 1/gain scaled by 16384

  typedef struct packed {
    vec_word_t x;
    vec_word_t y;
    vec_word_t z;
  } csc_vec_t;

  typedef enum logic [0:0] {
    REG_ITER_COUNT = 1'b0
  } csc_reg_t;

  localparam logic [13:0] ATAN_TABLE [ATAN_LEN] = '{
    14'h3243, 14'h1DAC, 14'h0FAD, 14'h07F5, 14'h03FE, 14'h01FF, 14'h00FF, 14'h007F,
    14'h003F, 14'h001F, 14'h000F, 14'h0007, 14'h0003, 14'h0001, 14'h0000, 14'h0000
  };

  // atan(2^-k) * 16384; zero past the end of the table
  function automatic vec_word_t atan_angle(input logic [STEP_W-1:0] k);
    vec_word_t res;
    res = '0;
    if ({1'b0, k} < (STEP_W+1)'(ATAN_LEN)) begin
      res = vec_word_t'({4'b0, ATAN_TABLE[k[ATAN_IDX_W-1:0]]});
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/cordic_sin_cos_q14_unit.sv =====
// Top level of the rotation-mode CORDIC sin/cos unit, Q14 angle in, Q14 cos/sin out.
// Depends on csc_pkg, csc_stage, csc_cfg and cordic_sin_cos_q14_unit_defines.svh.
//
// Usage:
//  - Request channel: drive in_angle (radians * 16384, signed) and raise start.
//    A request is taken at every clock edge where start is high and busy is
//    low; busy stays low, so a new angle may be issued every cycle.
//  - Result channel: out_valid pulses for one cycle with out_cosine and
//    out_sine (low 16 bits of the final x and y). The receiver cannot stall,
//    so results simply fall out of the pipe in request order.
//  - A request taken at an edge passes through the 17 unrolled micro-rotation
//    stages, one register stage each, and shows on the outputs straight from
//    the last stage register. Throughput is one request per cycle.
//  - The iteration count n (APB, byte address 0, reset 16, clamped to 16)
//    turns stages k > n into pass-through; latency does not change with n.
//    Write it only while no request is in flight.
//  - Reset (rst_n low, synchronous) clears all stage valid bits and restores
//    n = 16; requests in flight at reset are dropped.
`default_nettype none
`include "cordic_sin_cos_q14_unit_defines.svh"

module cordic_sin_cos_q14_unit
  import csc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // request channel
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [DATA_W-1:0]  in_angle,
  // result channel
  output logic                           out_valid,
  output logic signed      [DATA_W-1:0]  out_cosine,
  output logic signed      [DATA_W-1:0]  out_sine,
  // configuration (APB)
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic        [ADDR_W-1:0]  paddr,
  input  wire logic        [PDATA_W-1:0] pwdata,
  output logic             [PDATA_W-1:0] prdata,
  output logic                           pready
);

  logic [NUM_STAGES-1:0] stage_en;
  logic                  stage_valid [NUM_STAGES];
  csc_vec_t              stage_vec   [NUM_STAGES];
  csc_vec_t              head_vec;
  logic                  accept;

  // fully pipelined, never backpressures
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // starting vector: x = 1/gain, y = 0, z = angle
  always_comb begin
    head_vec.x = X_START;
    head_vec.y = '0;
    head_vec.z = vec_word_t'(in_angle);
  end

  csc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .stage_en (stage_en)
  );

  // micro-rotation k lives in stage k
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_head
      csc_stage u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (STEP_W'(k)),
        .en        (stage_en[k]),
        .in_valid  (accept),
        .in_vec    (head_vec),
        .out_valid (stage_valid[k]),
        .out_vec   (stage_vec[k])
      );
    end else begin : g_body
      csc_stage u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (STEP_W'(k)),
        .en        (stage_en[k]),
        .in_valid  (stage_valid[k-1]),
        .in_vec    (stage_vec[k-1]),
        .out_valid (stage_valid[k]),
        .out_vec   (stage_vec[k])
      );
    end
  end

  // outputs straight from the last stage register, truncated to 16 bits
  assign out_valid  = stage_valid[NUM_STAGES-1];
  assign out_cosine = stage_vec[NUM_STAGES-1].x[DATA_W-1:0];
  assign out_sine   = stage_vec[NUM_STAGES-1].y[DATA_W-1:0];

  // ---- assertions ----
  `CSC_ASSERT_DLY(a_req_latency, accept, LATENCY, out_valid, "request did not emerge after LATENCY cycles")
  `CSC_ASSERT_NXT(a_no_spurious, !stage_valid[NUM_STAGES-2], !out_valid, "result without a request behind it")
  `CSC_ASSERT_IMP(a_first_stage_on, 1'b1, stage_en[0], "first rotation disabled")
  `CSC_ASSERT_IMP(a_en_thermo, 1'b1, ((stage_en + 1'b1) & stage_en) == '0, "stage enables not contiguous from stage 0")

endmodule

`default_nettype wire

// ===== src/csc_stage.sv =====
// One registered CORDIC micro-rotation stage.
// Depends on csc_pkg.
`default_nettype none

module csc_stage
  import csc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [STEP_W-1:0] step,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire csc_vec_t          in_vec,
  output logic                   out_valid,
  output csc_vec_t               out_vec
);

  logic      valid_r;
  csc_vec_t  vec_r;
  csc_vec_t  vec_nxt;
  vec_word_t xs;
  vec_word_t ys;
  vec_word_t t;

  always_comb begin
    xs      = in_vec.x >>> step;
    ys      = in_vec.y >>> step;
    t       = atan_angle(step);
    vec_nxt = in_vec;
    if (en) begin
      if (!in_vec.z[VEC_W-1]) begin
        vec_nxt.x = in_vec.x - ys;
        vec_nxt.y = in_vec.y + xs;
        vec_nxt.z = in_vec.z - t;
      end else begin
        vec_nxt.x = in_vec.x + ys;
        vec_nxt.y = in_vec.y - xs;
        vec_nxt.z = in_vec.z + t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

endmodule

`default_nettype wire

// ===== src/csc_cfg.sv =====
// APB register block: iteration_count and the per-stage enables derived from it.
// Depends on csc_pkg.
`default_nettype none

module csc_cfg
  import csc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]    pwdata,
  output logic      [PDATA_W-1:0]    prdata,
  output logic                       pready,
  output logic      [NUM_STAGES-1:0] stage_en
);

  logic [CNT_W-1:0] iter_r;
  logic [CNT_W-1:0] iter_nxt;
  logic [CNT_W-1:0] n_eff;
  csc_reg_t         reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = csc_reg_t'(paddr[ADDR_W-1]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    iter_nxt = iter_r;
    prdata   = '0;
    case (reg_idx)
      REG_ITER_COUNT: begin
        prdata = PDATA_W'(iter_r);
        if (wr_en) begin
          iter_nxt = pwdata[CNT_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= ITER_RESET;
    end else begin
      iter_r <= iter_nxt;
    end
  end

  // clamp, then stage k runs when k <= n
  assign n_eff = (iter_r > CNT_W'(MAX_ITERATIONS)) ? CNT_W'(MAX_ITERATIONS) : iter_r;

  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      stage_en[i] = ((CNT_W+1)'(i) <= {1'b0, n_eff});
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/trig_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the CORDIC sin/cos unit: predicts cosine and sine per angle request.
// Depends on csc_pkg for the port widths.

class trig_scoreboard;

  typedef struct {
    logic signed [csc_pkg::DATA_W-1:0] angle;
    logic signed [csc_pkg::DATA_W-1:0] cosine;
    logic signed [csc_pkg::DATA_W-1:0] sine;
  } trig_pair_t;

  // atan(2^-k) * 16384
  int atan_q14[16] = '{
    'h3243, 'h1DAC, 'h0FAD, 'h07F5, 'h03FE, 'h01FF, 'h00FF, 'h007F,
    'h003F, 'h001F, 'h000F, 'h0007, 'h0003, 'h0001, 'h0000, 'h0000
  };

  int         step_count;
  trig_pair_t pending_trig[$];
  int         fail_count;

  function new();
    step_count = 16;
    fail_count = 0;
  endfunction

  function void set_steps(logic [31:0] wdata);
    step_count = int'(wdata[4:0]);
  endfunction

  function int outstanding();
    return pending_trig.size();
  endfunction

  // 32-bit rotation-mode CORDIC, n+1 micro-rotations, n clamped to 16
  function void note_angle(logic signed [csc_pkg::DATA_W-1:0] angle);
    int         x, y, z, xs, ys, t, n;
    trig_pair_t exp_pair;
    x = 'h26DD;
    y = 0;
    z = int'(angle);
    n = (step_count > 16) ? 16 : step_count;
    for (int k = 0; k <= n; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      t  = (k < 16) ? atan_q14[k] : 0;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - t;
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + t;
      end
    end
    exp_pair.angle  = angle;
    exp_pair.cosine = x[15:0];
    exp_pair.sine   = y[15:0];
    pending_trig.push_back(exp_pair);
  endfunction

  function void check_result(logic signed [csc_pkg::DATA_W-1:0] cosine,
                             logic signed [csc_pkg::DATA_W-1:0] sine);
    trig_pair_t exp_pair;
    if (pending_trig.size() == 0) begin
      $error("unexpected result: cosine %0d sine %0d", cosine, sine);
      fail_count++;
      return;
    end
    exp_pair = pending_trig.pop_front();
    if (cosine !== exp_pair.cosine) begin
      $error("cosine (angle %0d): expected %0d, actual %0d",
             exp_pair.angle, exp_pair.cosine, cosine);
      fail_count++;
    end
    if (sine !== exp_pair.sine) begin
      $error("sine (angle %0d): expected %0d, actual %0d",
             exp_pair.angle, exp_pair.sine, sine);
      fail_count++;
    end
  endfunction

endclass

// ===== tb/sv/cordic_sin_cos_q14_unit_test.sv =====
`timescale 1ns / 100ps
// Top-level testbench for cordic_sin_cos_q14_unit: directed and random angle requests,
// APB writes of the iteration count between phases. Depends on csc_pkg and trig_scoreboard.

module cordic_sin_cos_q14_unit_test;
  import csc_pkg::*;

  localparam int SEGMENTS     = 9;
  localparam int SEG_REQUESTS = 215;
  localparam int RAND_STEPS   = -1;   // marker: pick a random iteration count

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [DATA_W-1:0]  in_angle;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_cosine;
  logic signed [DATA_W-1:0]  out_sine;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic        [ADDR_W-1:0]  paddr;
  logic        [PDATA_W-1:0] pwdata;
  logic        [PDATA_W-1:0] prdata;
  logic                      pready;

  trig_scoreboard sb = new();

  // Corner angles: zero (the z >= 0 tie), +-1 LSB, +-pi/2, +-pi/4, +-pi/6,
  // full-scale values outside +-pi/2, and alternating bit patterns.
  logic signed [DATA_W-1:0] corner_angles [20] = '{
    16'sd0, 16'sd1, -16'sd1, 16'sd2, -16'sd2,
    16'sd25735, -16'sd25736, 16'sd12868, -16'sd12868, 16'sd8579,
    -16'sd8579, 16'sd4096, -16'sd4096, 16'sd32767, -16'sd32768,
    16'sd16384, -16'sd16384, 16'sh5555, -16'sd21846, 16'sd100
  };

  // Per-phase iteration count and sender idle rate. The first three phases
  // idle 35%, the next three 74%, the last three run back to back. Counts
  // cover both extremes (0 and 31, which clamps to 16) and the clamp edge.
  int seg_steps [SEGMENTS] = '{0, 31, 1, 16, 17, RAND_STEPS, 15, 8, RAND_STEPS};
  int seg_idle  [SEGMENTS] = '{35, 35, 35, 74, 74, 74, 0, 0, 0};

  cordic_sin_cos_q14_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_cosine(out_cosine),
    .out_sine  (out_sine),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Monitor: everything is driven at the falling edge, so at the rising edge
  // the request side is stable and the outputs still hold the pre-edge values.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (start && !busy) begin
        sb.note_angle(in_angle);
      end
      if (out_valid) begin
        sb.check_result(out_cosine, out_sine);
      end
    end
  end

  // Mostly in-range angles, some full-range (all 16 bits toggle), a few corners.
  function automatic logic signed [DATA_W-1:0] pick_angle();
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) begin
      return DATA_W'(int'($urandom_range(51471)) - 25736);
    end else if (sel < 95) begin
      return DATA_W'($urandom);
    end
    return corner_angles[$urandom_range(19)];
  endfunction

  // One request; waits out random idle cycles first, then holds start until taken.
  // start is left high after acceptance: the next negedge either lowers it
  // or presents the next request, so each edge sees one assignment only.
  task automatic send_angle(input logic signed [DATA_W-1:0] angle, input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    in_angle <= angle;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop issuing and let the pipe empty, then keep running for longer than the pipeline latency.
  task automatic drain_pipe();
    @(negedge clk);
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; takes effect when pready is high.
  task automatic write_steps(input logic [PDATA_W-1:0] wdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(REG_ITER_COUNT));
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_steps(wdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int steps;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_angle = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners at the reset count (16 -> 17 rotations).
    foreach (corner_angles[i]) begin
      send_angle(corner_angles[i], 0);
    end
    drain_pipe();

    // Random phases; the count is rewritten only once the pipe is empty.
    // Upper write-data bits are random and must be ignored.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      steps = (seg_steps[seg] == RAND_STEPS) ? int'($urandom_range(31)) : seg_steps[seg];
      write_steps(($urandom & ~32'h1F) | PDATA_W'(steps));
      for (int i = 0; i < SEG_REQUESTS; i++) begin
        send_angle(pick_angle(), seg_idle[seg]);
      end
      drain_pipe();
    end

    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under 100 us.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
